[rtl/core/population_std_deviation_assert.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the standard deviation block
// Checks that hold at every clock edge and checks that look at the next cycle.
// ----------------------------------------------------------------------------
`ifndef POPULATION_STD_DEVIATION_ASSERT_SVH
`define POPULATION_STD_DEVIATION_ASSERT_SVH
`ifndef NO_ASSERTIONS
// check a condition at every clock edge outside reset
`define PSD_ASSERT(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);
// check that a condition in the next cycle follows from a condition now
`define PSD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define PSD_ASSERT(lbl, expr, msg)
`define PSD_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

[rtl/core/psd_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// psd_pkg
// Shared types and constants of the standard deviation block.
// ----------------------------------------------------------------------------
package psd_pkg;

  // fixed port widths
  localparam int IN_W      = 16;
  localparam int OUT_STD_W = 24;
  localparam int OUT_CNT_W = 11;

  // batch queue between accumulator and arithmetic engine
  localparam int Q_DEPTH = 2;

  typedef struct packed {
    logic empty;
    logic full;
    logic almost_full;
  } q_stat_t;

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_MUL_A,
    PH_MUL_B,
    PH_SQRT,
    PH_DIV,
    PH_HOLD
  } phase_t;

endpackage
`default_nettype wire

[rtl/core/psd_front.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// psd_front
// Takes one sample a cycle while full is low, keeps count, sum and sum of squares, and hands
// the totals of each finished batch to the batch queue.
// ----------------------------------------------------------------------------
`include "population_std_deviation_assert.svh"

module psd_front #(
  parameter int MAX_SAMPLES   = 1024,
  parameter int SAMPLE_BITS   = 16,
  parameter int CW            = $clog2(MAX_SAMPLES + 1),
  parameter int SW            = SAMPLE_BITS + CW,
  parameter int S2W           = 2 * SAMPLE_BITS + CW - 1
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic signed [psd_pkg::IN_W-1:0] sample,
  input  wire logic                       last_sample,
  input  wire logic                       push,
  output logic                            full,
  input  wire psd_pkg::q_stat_t           q_stat,
  output logic                            rec_push,
  output logic [CW-1:0]                   rec_cnt,
  output logic signed [SW-1:0]            rec_sum,
  output logic [S2W-1:0]                  rec_sq,
  output logic                            rec_ovf
);

  localparam int SQW = 2 * SAMPLE_BITS;

  logic                          accept;
  logic signed [SAMPLE_BITS-1:0] x_in;
  logic [SQW-1:0]                sq_in;

  // input stage
  logic                          in_v;
  logic signed [SAMPLE_BITS-1:0] x_r;
  logic [SQW-1:0]                sq_r;
  logic                          last_r;

  // accumulators
  logic [CW-1:0]        cnt, cnt_next;
  logic signed [SW-1:0] sum, sum_next;
  logic [S2W-1:0]       sqa, sqa_next;
  logic                 ovf, ovf_next;

  // leave room for a batch end still in the input stage
  assign full   = q_stat.full || (q_stat.almost_full && in_v && last_r);
  assign accept = push && !full;

  assign x_in  = sample[SAMPLE_BITS-1:0];
  assign sq_in = SQW'(x_in * x_in);

  always_ff @(posedge clk) begin
    if (rst) begin
      in_v <= 1'b0;
    end else begin
      in_v <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      x_r    <= x_in;
      sq_r   <= sq_in;
      last_r <= last_sample;
    end
  end

  always_comb begin
    cnt_next = cnt;
    sum_next = sum;
    sqa_next = sqa;
    ovf_next = ovf;
    rec_push = 1'b0;
    if (in_v) begin
      if (cnt < CW'(MAX_SAMPLES)) begin
        sum_next = sum + SW'(x_r);
        sqa_next = sqa + S2W'(sq_r);
        cnt_next = cnt + CW'(1);
      end else begin
        ovf_next = 1'b1;
      end
      rec_push = last_r;
    end
  end

  assign rec_cnt = cnt_next;
  assign rec_sum = sum_next;
  assign rec_sq  = sqa_next;
  assign rec_ovf = ovf_next;

  // drop the totals once the batch is handed over
  always_ff @(posedge clk) begin
    if (rst || rec_push) begin
      cnt <= '0;
      sum <= '0;
      sqa <= '0;
      ovf <= 1'b0;
    end else begin
      cnt <= cnt_next;
      sum <= sum_next;
      sqa <= sqa_next;
      ovf <= ovf_next;
    end
  end

  `PSD_ASSERT(a_cnt_bound, cnt <= CW'(MAX_SAMPLES), "sample count beyond limit")
  `PSD_ASSERT_NEXT(a_batch_clear, in_v && last_r, cnt == '0 && !ovf, "batch not cleared")

endmodule
`default_nettype wire

[rtl/core/psd_queue.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// psd_queue
// Short queue of batch totals between accumulator and arithmetic engine.
// ----------------------------------------------------------------------------
`include "population_std_deviation_assert.svh"

module psd_queue #(
  parameter int W = 81
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             wr,
  input  wire logic [W-1:0]     din,
  input  wire logic             rd,
  output logic [W-1:0]          dout,
  output psd_pkg::q_stat_t      q_stat
);

  localparam int QPW = (psd_pkg::Q_DEPTH > 1) ? $clog2(psd_pkg::Q_DEPTH) : 1;
  localparam int QUW = $clog2(psd_pkg::Q_DEPTH + 1);

  logic [W-1:0]   entry [psd_pkg::Q_DEPTH];
  logic [QPW-1:0] wr_ptr;
  logic [QPW-1:0] rd_ptr;
  logic [QUW-1:0] used;

  function automatic logic [QPW-1:0] ptr_inc(input logic [QPW-1:0] p);
    return (p == QPW'(psd_pkg::Q_DEPTH - 1)) ? '0 : p + QPW'(1);
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      used   <= '0;
    end else begin
      if (wr) begin
        wr_ptr <= ptr_inc(wr_ptr);
      end
      if (rd) begin
        rd_ptr <= ptr_inc(rd_ptr);
      end
      case ({wr, rd})
        2'b10:   used <= used + QUW'(1);
        2'b01:   used <= used - QUW'(1);
        default: used <= used;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (wr) begin
      entry[wr_ptr] <= din;
    end
  end

  assign dout               = entry[rd_ptr];
  assign q_stat.empty       = (used == '0);
  assign q_stat.full        = (used == QUW'(psd_pkg::Q_DEPTH));
  assign q_stat.almost_full = (used >= QUW'(psd_pkg::Q_DEPTH - 1));

  `PSD_ASSERT(a_no_overrun, !(wr && q_stat.full), "write into full batch queue")
  `PSD_ASSERT(a_no_underrun, !(rd && q_stat.empty), "read from empty batch queue")

endmodule
`default_nettype wire

[rtl/core/psd_engine.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// psd_engine
// Per batch: n*S2 - S1^2 by shift and add, integer square root two bits a
// step, division by n one bit a step, then the output register.
// ----------------------------------------------------------------------------
`include "population_std_deviation_assert.svh"

module psd_engine #(
  parameter int MAX_SAMPLES   = 1024,
  parameter int SAMPLE_BITS   = 16,
  parameter int FRACTION_BITS = 8,
  parameter int CW            = $clog2(MAX_SAMPLES + 1),
  parameter int SW            = SAMPLE_BITS + CW,
  parameter int S2W           = 2 * SAMPLE_BITS + CW - 1
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire psd_pkg::q_stat_t               q_stat,
  output logic                                rec_pop,
  input  wire logic [CW-1:0]                  rec_cnt,
  input  wire logic signed [SW-1:0]           rec_sum,
  input  wire logic [S2W-1:0]                 rec_sq,
  input  wire logic                           rec_ovf,
  output logic [psd_pkg::OUT_STD_W-1:0]       std_dev,
  output logic [psd_pkg::OUT_CNT_W-1:0]       sample_count,
  output logic                                overflow,
  output logic                                empty,
  input  wire logic                           pop
);

  localparam int PW  = 2 * SW;               // n*S2 - S1^2
  localparam int QW  = SW + FRACTION_BITS;   // root and quotient
  localparam int RMW = QW + 2;               // root remainder
  localparam int STW = $clog2(QW + 1);

  psd_pkg::phase_t state, state_next;

  logic [STW-1:0] step, step_next;
  logic [CW-1:0]  n_r, n_next;
  logic           ovf_r, ovf_next;
  logic [SW-1:0]  mag_r, mag_next;
  logic [PW-1:0]  md, md_next;
  logic [SW-1:0]  mr, mr_next;
  logic [PW-1:0]  acc, acc_next;
  logic [QW-1:0]  root, root_next;
  logic [RMW-1:0] rem, rem_next;
  logic [CW-1:0]  drem, drem_next;

  logic           out_valid, out_valid_next;
  logic [psd_pkg::OUT_STD_W-1:0] out_sd;
  logic [psd_pkg::OUT_CNT_W-1:0] out_cnt;
  logic           out_ovf;
  logic           load;

  logic [SW-1:0]  rec_mag;
  logic [RMW-1:0] rem_sh;
  logic [RMW-1:0] trial;
  logic [CW:0]    dsh;
  logic           qbit;

  assign rec_mag = rec_sum[SW-1] ? $unsigned(-rec_sum) : $unsigned(rec_sum);
  assign rem_sh  = {rem[RMW-3:0], acc[PW-1:PW-2]};
  assign trial   = {root, 2'b01};
  assign dsh     = {drem, root[QW-1]};
  assign qbit    = (dsh >= {1'b0, n_r});

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= psd_pkg::PH_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    step  <= step_next;
    n_r   <= n_next;
    ovf_r <= ovf_next;
    mag_r <= mag_next;
    md    <= md_next;
    mr    <= mr_next;
    acc   <= acc_next;
    root  <= root_next;
    rem   <= rem_next;
    drem  <= drem_next;
    if (load) begin
      out_sd  <= psd_pkg::OUT_STD_W'(root);
      out_cnt <= psd_pkg::OUT_CNT_W'(n_r);
      out_ovf <= ovf_r;
    end
  end

  always_comb begin
    state_next = state;
    step_next  = step;
    n_next     = n_r;
    ovf_next   = ovf_r;
    mag_next   = mag_r;
    md_next    = md;
    mr_next    = mr;
    acc_next   = acc;
    root_next  = root;
    rem_next   = rem;
    drem_next  = drem;
    rec_pop    = 1'b0;
    load       = 1'b0;
    unique case (state)
      psd_pkg::PH_IDLE: begin
        if (!q_stat.empty) begin
          rec_pop    = 1'b1;
          n_next     = rec_cnt;
          ovf_next   = rec_ovf;
          mag_next   = rec_mag;
          acc_next   = '0;
          md_next    = PW'(rec_sq);
          mr_next    = SW'(rec_cnt);
          step_next  = STW'(CW);
          state_next = psd_pkg::PH_MUL_A;
        end
      end
      psd_pkg::PH_MUL_A: begin
        // add n * S2
        if (mr[0]) begin
          acc_next = acc + md;
        end
        md_next   = md << 1;
        mr_next   = mr >> 1;
        step_next = step - STW'(1);
        if (step == STW'(1)) begin
          md_next    = PW'(mag_r);
          mr_next    = mag_r;
          step_next  = STW'(SW);
          state_next = psd_pkg::PH_MUL_B;
        end
      end
      psd_pkg::PH_MUL_B: begin
        // subtract S1^2
        if (mr[0]) begin
          acc_next = acc - md;
        end
        md_next   = md << 1;
        mr_next   = mr >> 1;
        step_next = step - STW'(1);
        if (step == STW'(1)) begin
          rem_next   = '0;
          root_next  = '0;
          step_next  = STW'(QW);
          state_next = psd_pkg::PH_SQRT;
        end
      end
      psd_pkg::PH_SQRT: begin
        // bring in two radicand bits; zeros past the end give the fraction
        if (rem_sh >= trial) begin
          rem_next  = rem_sh - trial;
          root_next = {root[QW-2:0], 1'b1};
        end else begin
          rem_next  = rem_sh;
          root_next = {root[QW-2:0], 1'b0};
        end
        acc_next  = acc << 2;
        step_next = step - STW'(1);
        if (step == STW'(1)) begin
          drem_next  = '0;
          step_next  = STW'(QW);
          state_next = psd_pkg::PH_DIV;
        end
      end
      psd_pkg::PH_DIV: begin
        // quotient bits replace root bits from the bottom
        drem_next = qbit ? CW'(dsh - {1'b0, n_r}) : dsh[CW-1:0];
        root_next = {root[QW-2:0], qbit};
        step_next = step - STW'(1);
        if (step == STW'(1)) begin
          state_next = psd_pkg::PH_HOLD;
        end
      end
      psd_pkg::PH_HOLD: begin
        if (!out_valid || pop) begin
          load       = 1'b1;
          state_next = psd_pkg::PH_IDLE;
        end
      end
      default: begin
        state_next = psd_pkg::PH_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_next = out_valid;
    if (load) begin
      out_valid_next = 1'b1;
    end else if (pop && out_valid) begin
      out_valid_next = 1'b0;
    end
  end

  assign std_dev      = out_sd;
  assign sample_count = out_cnt;
  assign overflow     = out_ovf;
  assign empty        = !out_valid;

  `PSD_ASSERT_NEXT(a_start, state == psd_pkg::PH_IDLE && !q_stat.empty, state == psd_pkg::PH_MUL_A, "engine did not take waiting batch")
  `PSD_ASSERT(a_batch_nonempty, state == psd_pkg::PH_IDLE || n_r != '0, "empty batch in engine")

endmodule
`default_nettype wire

[rtl/core/population_std_deviation.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// population_std_deviation
// Population standard deviation of batches of signed samples, unsigned
// fixed point with FRACTION_BITS fraction bits, rounded down.
// ----------------------------------------------------------------------------
//
//   channel  | handshake           | words
//   ---------+---------------------+-----------------------------------------
//   input    | push / full         | sample, last_sample
//   result   | pop / empty         | std_dev, sample_count, overflow
//
// Samples go in one a cycle while full is low; full rises while the batch queue holds two
// batches, or holds one with another batch end still in the input stage.
// A result passes from the input stage through the batch queue, the engine's
// shift-add, root and divide steps and the output register. The engine
// works on one batch at a time and takes the next only after it is done,
// so short batches wait in the queue.
// Reset (rst, synchronous) clears all control and accumulators at once.
// A result not yet popped holds the engine; the queue then absorbs batches.
//

module population_std_deviation #(
  parameter int MAX_SAMPLES   = 1024,
  parameter int SAMPLE_BITS   = 16,
  parameter int FRACTION_BITS = 8
) (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic signed [psd_pkg::IN_W-1:0]    sample,
  input  wire logic                               last_sample,
  input  wire logic                               push,
  output logic                                    full,
  output logic [psd_pkg::OUT_STD_W-1:0]           std_dev,
  output logic [psd_pkg::OUT_CNT_W-1:0]           sample_count,
  output logic                                    overflow,
  output logic                                    empty,
  input  wire logic                               pop
);

  // widths of the batch totals
  localparam int CW  = $clog2(MAX_SAMPLES + 1);
  localparam int SW  = SAMPLE_BITS + CW;
  localparam int S2W = 2 * SAMPLE_BITS + CW - 1;
  localparam int RW  = 1 + CW + SW + S2W;

  psd_pkg::q_stat_t     q_stat;
  logic                 rec_push;
  logic                 rec_pop;
  logic [CW-1:0]        f_cnt;
  logic signed [SW-1:0] f_sum;
  logic [S2W-1:0]       f_sq;
  logic                 f_ovf;
  logic [RW-1:0]        rec_in;
  logic [RW-1:0]        rec_out;
  logic [CW-1:0]        e_cnt;
  logic signed [SW-1:0] e_sum;
  logic [S2W-1:0]       e_sq;
  logic                 e_ovf;

  // accumulate samples, hand over batch totals
  psd_front #(
    .MAX_SAMPLES (MAX_SAMPLES),
    .SAMPLE_BITS (SAMPLE_BITS),
    .CW          (CW),
    .SW          (SW),
    .S2W         (S2W)
  ) u_front (
    .clk         (clk),
    .rst         (rst),
    .sample      (sample),
    .last_sample (last_sample),
    .push        (push),
    .full        (full),
    .q_stat      (q_stat),
    .rec_push    (rec_push),
    .rec_cnt     (f_cnt),
    .rec_sum     (f_sum),
    .rec_sq      (f_sq),
    .rec_ovf     (f_ovf)
  );

  // pack one batch word: overflow, count, sum, sum of squares
  assign rec_in = {f_ovf, f_cnt, f_sum, f_sq};

  psd_queue #(
    .W (RW)
  ) u_queue (
    .clk    (clk),
    .rst    (rst),
    .wr     (rec_push),
    .din    (rec_in),
    .rd     (rec_pop),
    .dout   (rec_out),
    .q_stat (q_stat)
  );

  assign e_sq  = rec_out[S2W-1:0];
  assign e_sum = $signed(rec_out[S2W +: SW]);
  assign e_cnt = rec_out[S2W + SW +: CW];
  assign e_ovf = rec_out[RW-1];

  // variance, root and division once per batch
  psd_engine #(
    .MAX_SAMPLES   (MAX_SAMPLES),
    .SAMPLE_BITS   (SAMPLE_BITS),
    .FRACTION_BITS (FRACTION_BITS),
    .CW            (CW),
    .SW            (SW),
    .S2W           (S2W)
  ) u_engine (
    .clk          (clk),
    .rst          (rst),
    .q_stat       (q_stat),
    .rec_pop      (rec_pop),
    .rec_cnt      (e_cnt),
    .rec_sum      (e_sum),
    .rec_sq       (e_sq),
    .rec_ovf      (e_ovf),
    .std_dev      (std_dev),
    .sample_count (sample_count),
    .overflow     (overflow),
    .empty        (empty),
    .pop          (pop)
  );

endmodule
`default_nettype wire
